[rtl/transformed_sphere_bounding_box_assert.svh]
// Assertion macros for the sphere bounding box pipeline.
`ifndef TRANSFORMED_SPHERE_BOUNDING_BOX_ASSERT_SVH
`define TRANSFORMED_SPHERE_BOUNDING_BOX_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define TSBB_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tsbb check failed");

// Antecedent implies consequent in the same cycle.
`define TSBB_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsbb check failed");

`endif

[rtl/tsbb_pkg.sv]
// Types and constants for the sphere bounding box pipeline.
package tsbb_pkg;

  localparam int CoordW       = 32;
  localparam int SqW          = 2 * CoordW;     // square and sum of squares
  localparam int RootW        = SqW / 2;        // floor sqrt of the sum
  localparam int RemW         = RootW + 2;      // sqrt partial remainder
  localparam int BoundW       = CoordW + 2;     // t +/- h before saturation
  localparam int NumAxes      = 3;
  localparam int NumLin       = 3;
  localparam int RootPerStage = 2;              // root bits resolved per stage
  localparam int SqrtStages   = RootW / RootPerStage;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t r0c0;
    coord_t r0c1;
    coord_t r0c2;
    coord_t r0t;
    coord_t r1c0;
    coord_t r1c1;
    coord_t r1c2;
    coord_t r1t;
    coord_t r2c0;
    coord_t r2c1;
    coord_t r2c2;
    coord_t r2t;
  } item_t;

  typedef struct packed {
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
    coord_t min_z;
    coord_t max_z;
  } box_t;

endpackage

[rtl/transformed_sphere_bounding_box.sv]
// Top level: pipelined bounding box of the unit sphere under a 3x4 affine transform.
// Stages from input transfer to result: abs, square, sum, the sqrt chain, bounds.
// One item per cycle while no result is held; sqrt stages take two root bits each.
// A held result stalls the whole pipeline in place; nothing is dropped or repeated.
// rst clears the stage valid bits only; data registers are not reset.
module transformed_sphere_bounding_box (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  tsbb_pkg::item_t item,
  output logic            box_valid,
  input  logic            box_stall,
  output tsbb_pkg::box_t  box
);
  import tsbb_pkg::*;

  logic advance;

  coord_t lin_in [NumAxes][NumLin];
  coord_t t_in   [NumAxes];

  // stage 1: magnitudes
  logic              v1;
  logic [CoordW-1:0] mag1 [NumAxes][NumLin];
  coord_t            t1   [NumAxes];

  // stage 2: squares
  logic              v2;
  logic [SqW-1:0]    sq2 [NumAxes][NumLin];
  coord_t            t2  [NumAxes];

  // stage 3: sum of squares
  logic              v3;
  logic [SqW-1:0]    sum3 [NumAxes];
  coord_t            t3   [NumAxes];

  // sqrt stages
  logic              sr_v    [SqrtStages];
  logic [SqW-1:0]    sr_rad  [SqrtStages][NumAxes];
  logic [RemW-1:0]   sr_rem  [SqrtStages][NumAxes];
  logic [RootW-1:0]  sr_root [SqrtStages][NumAxes];
  coord_t            sr_t    [SqrtStages][NumAxes];

  logic [SqW-1:0]    rad_next  [SqrtStages][NumAxes];
  logic [RemW-1:0]   rem_next  [SqrtStages][NumAxes];
  logic [RootW-1:0]  root_next [SqrtStages][NumAxes];

  logic signed [BoundW-1:0] lo_wide [NumAxes];
  logic signed [BoundW-1:0] hi_wide [NumAxes];
  coord_t                   lo_sat  [NumAxes];
  coord_t                   hi_sat  [NumAxes];

  logic rem_in_range;

  function automatic coord_t sat_bound(input logic signed [BoundW-1:0] v);
    coord_t r;
    if (v[BoundW-1:CoordW-1] == '0 || v[BoundW-1:CoordW-1] == '1) begin
      r = v[CoordW-1:0];
    end else if (v[BoundW-1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

  // whole pipeline moves together unless the result register is held
  assign advance    = !(box_valid && box_stall);
  assign item_stall = !advance;

  assign lin_in[0][0] = item.r0c0;
  assign lin_in[0][1] = item.r0c1;
  assign lin_in[0][2] = item.r0c2;
  assign lin_in[1][0] = item.r1c0;
  assign lin_in[1][1] = item.r1c1;
  assign lin_in[1][2] = item.r1c2;
  assign lin_in[2][0] = item.r2c0;
  assign lin_in[2][1] = item.r2c1;
  assign lin_in[2][2] = item.r2c2;
  assign t_in[0]      = item.r0t;
  assign t_in[1]      = item.r1t;
  assign t_in[2]      = item.r2t;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int a = 0; a < NumAxes; a++) begin
        for (int j = 0; j < NumLin; j++) begin
          // -2^31 maps to 2^31, still exact in 32 unsigned bits
          mag1[a][j] <= lin_in[a][j][CoordW-1] ? (~lin_in[a][j] + 1'b1) : lin_in[a][j];
          sq2[a][j]  <= mag1[a][j] * mag1[a][j];
        end
        t1[a]   <= t_in[a];
        t2[a]   <= t1[a];
        sum3[a] <= sq2[a][0] + sq2[a][1] + sq2[a][2];
        t3[a]   <= t2[a];
      end
    end
  end

  // restoring digit-by-digit square root, RootPerStage root bits per stage
  for (genvar k = 0; k < SqrtStages; k++) begin : g_sqrt
    logic v_prev;

    if (k == 0) begin : g_v_first
      assign v_prev = v3;
    end else begin : g_v_rest
      assign v_prev = sr_v[k-1];
    end

    for (genvar a = 0; a < NumAxes; a++) begin : g_axis
      logic [SqW-1:0]   rad_in;
      logic [RemW-1:0]  rem_in;
      logic [RootW-1:0] root_in;
      coord_t           t_prev;

      if (k == 0) begin : g_first
        assign rad_in  = sum3[a];
        assign rem_in  = '0;
        assign root_in = '0;
        assign t_prev  = t3[a];
      end else begin : g_rest
        assign rad_in  = sr_rad[k-1][a];
        assign rem_in  = sr_rem[k-1][a];
        assign root_in = sr_root[k-1][a];
        assign t_prev  = sr_t[k-1][a];
      end

      always_comb begin : step
        logic [RemW:0]    cur;
        logic [RemW:0]    trial;
        logic [RemW-1:0]  r;
        logic [RootW-1:0] q;
        logic [SqW-1:0]   rd;
        r     = rem_in;
        q     = root_in;
        rd    = rad_in;
        cur   = '0;
        trial = '0;
        for (int s = 0; s < RootPerStage; s++) begin
          cur   = {r[RemW-2:0], rd[SqW-1 -: 2]};
          trial = {1'b0, q, 2'b01};
          rd    = {rd[SqW-3:0], 2'b00};
          if (cur >= trial) begin
            r = RemW'(cur - trial);
            q = {q[RootW-2:0], 1'b1};
          end else begin
            r = cur[RemW-1:0];
            q = {q[RootW-2:0], 1'b0};
          end
        end
        rad_next[k][a]  = rd;
        rem_next[k][a]  = r;
        root_next[k][a] = q;
      end

      always_ff @(posedge clk) begin
        if (advance) begin
          sr_rad[k][a]  <= rad_next[k][a];
          sr_rem[k][a]  <= rem_next[k][a];
          sr_root[k][a] <= root_next[k][a];
          sr_t[k][a]    <= t_prev;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sr_v[k] <= 1'b0;
      end else if (advance) begin
        sr_v[k] <= v_prev;
      end
    end
  end

  for (genvar a = 0; a < NumAxes; a++) begin : g_bound
    assign lo_wide[a] = BoundW'(sr_t[SqrtStages-1][a])
                      - $signed({2'b00, sr_root[SqrtStages-1][a]});
    assign hi_wide[a] = BoundW'(sr_t[SqrtStages-1][a])
                      + $signed({2'b00, sr_root[SqrtStages-1][a]});
    assign lo_sat[a]  = sat_bound(lo_wide[a]);
    assign hi_sat[a]  = sat_bound(hi_wide[a]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (advance) begin
      box_valid <= sr_v[SqrtStages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      box.min_x <= lo_sat[0];
      box.max_x <= hi_sat[0];
      box.min_y <= lo_sat[1];
      box.max_y <= hi_sat[1];
      box.min_z <= lo_sat[2];
      box.max_z <= hi_sat[2];
    end
  end

  assign rem_in_range = {1'b0, sr_rem[SqrtStages-1][0]}
                     <= {2'b00, sr_root[SqrtStages-1][0], 1'b0};

`include "transformed_sphere_bounding_box_assert.svh"

  // half-extent is never negative, so saturated bounds stay ordered
  `TSBB_ASSERT_IMPLIES(a_order_x, box_valid, box.min_x <= box.max_x)
  `TSBB_ASSERT_IMPLIES(a_order_y, box_valid, box.min_y <= box.max_y)
  `TSBB_ASSERT_IMPLIES(a_order_z, box_valid, box.min_z <= box.max_z)
  // floor sqrt leaves a remainder of at most twice the root
  `TSBB_ASSERT_ALWAYS(a_sqrt_rem, !sr_v[SqrtStages-1] || rem_in_range)

endmodule
